>>> src/gcm_pkg.sv
// ============================================================================
// gcm_pkg
// Shared types, constants and helper functions for the grid cell mapper and
// box tile enumerator.
// ============================================================================
package gcm_pkg;

    localparam int AXES               = 3;
    localparam int MAX_CELLS_PER_AXIS = 4;
    localparam int FRAC_BITS          = 16;
    localparam int SHIFT              = 2 * FRAC_BITS;

    localparam int DATA_W    = 32;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int Q_W       = PROD_W - SHIFT;
    localparam int K_W       = 3;
    localparam int CELL_W    = (MAX_CELLS_PER_AXIS > 1) ? $clog2(MAX_CELLS_PER_AXIS) : 1;
    localparam int TILE_W    = 7;
    localparam int CFG_IDX_W = 3;

    typedef enum logic {
        CMD_POINT = 1'b0,
        CMD_BOX   = 1'b1
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIGIN0 = 3'd0,
        CFG_ORIGIN1 = 3'd1,
        CFG_ORIGIN2 = 3'd2,
        CFG_SCALE0  = 3'd3,
        CFG_SCALE1  = 3'd4,
        CFG_SCALE2  = 3'd5,
        CFG_CELLS   = 3'd6
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIFF,
        ST_MUL,
        ST_EMIT
    } t_state;

    typedef struct packed {
        t_cmd               cmd;
        logic signed [31:0] pos_0;
        logic signed [31:0] pos_1;
        logic signed [31:0] pos_2;
        logic signed [31:0] upper_0;
        logic signed [31:0] upper_1;
        logic signed [31:0] upper_2;
    } t_in_item;

    typedef struct packed {
        logic [TILE_W-1:0] tile_id;
        logic              last;
    } t_out_item;

    typedef struct packed {
        logic load;
        logic step;
        logic point;
    } t_merge_ctrl;

    typedef logic [AXES-1:0][CELL_W-1:0] t_cells;

    // cells_per_axis: zero acts as one, large values saturate
    function automatic logic [K_W-1:0] grid_k(input logic [K_W-1:0] raw);
        logic [K_W-1:0] k;
        if (raw == '0) begin
            k = K_W'(1);
        end else if (raw > K_W'(MAX_CELLS_PER_AXIS)) begin
            k = K_W'(MAX_CELLS_PER_AXIS);
        end else begin
            k = raw;
        end
        return k;
    endfunction

    // row-major flatten, axis 0 most significant, plus one
    function automatic logic [TILE_W-1:0] flat_tile(input t_cells idx,
                                                    input logic [K_W-1:0] k);
        logic [TILE_W-1:0] c;
        c = '0;
        for (int a = 0; a < AXES; a++) begin
            c = TILE_W'(c * TILE_W'(k) + TILE_W'(idx[a]));
        end
        return TILE_W'(c + TILE_W'(1));
    endfunction

endpackage

>>> src/gcm_axis_lane.sv
// ============================================================================
// gcm_axis_lane
// One coordinate lane: offset from origin, scale multiply, floor and clamp to
// the cell range of the axis.
// ============================================================================
module gcm_axis_lane (
    input  logic                                   i_clk,
    input  logic                                   i_load,
    input  logic                                   i_mul,
    input  logic signed [gcm_pkg::DATA_W-1:0]      i_value,
    input  logic signed [gcm_pkg::DATA_W-1:0]      i_origin,
    input  logic        [gcm_pkg::DATA_W-1:0]      i_scale,
    input  logic        [gcm_pkg::K_W-1:0]         i_k,
    output logic        [gcm_pkg::CELL_W-1:0]      o_cell
);
    import gcm_pkg::*;

    logic signed [DATA_W:0]   w_diff;
    logic                     w_pos;
    logic [DATA_W-1:0]        r_mag;
    logic [DATA_W-1:0]        n_mag;
    logic [PROD_W-1:0]        r_prod;
    logic [PROD_W-1:0]        n_prod;
    logic [Q_W-1:0]           w_q;

    assign w_diff = {i_value[DATA_W-1], i_value} - {i_origin[DATA_W-1], i_origin};
    assign w_pos  = !w_diff[DATA_W] && (w_diff != '0);
    assign n_mag  = w_pos ? w_diff[DATA_W-1:0] : '0;
    assign n_prod = PROD_W'(r_mag) * PROD_W'(i_scale);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_mag <= n_mag;
        end
        if (i_mul) begin
            r_prod <= n_prod;
        end
    end

    assign w_q = r_prod[PROD_W-1:SHIFT];

    always_comb begin
        if (w_q >= Q_W'(i_k)) begin
            o_cell = CELL_W'(i_k - K_W'(1));
        end else begin
            o_cell = CELL_W'(w_q);
        end
    end

endmodule

>>> src/gcm_box_merge.sv
// ============================================================================
// gcm_box_merge
// Merges lane cells into per-axis ranges (ordered, inclusive) and walks the
// covered tiles, last axis fastest.
// ============================================================================
module gcm_box_merge (
    input  logic                          i_clk,
    input  gcm_pkg::t_merge_ctrl          i_ctrl,
    input  logic [gcm_pkg::K_W-1:0]       i_k,
    input  gcm_pkg::t_cells               i_lo_cell,
    input  gcm_pkg::t_cells               i_hi_cell,
    output gcm_pkg::t_out_item            o_item
);
    import gcm_pkg::*;

    t_cells r_lo;
    t_cells r_hi;
    t_cells r_idx;
    t_cells n_lo;
    t_cells n_hi;
    t_cells n_step;
    logic   w_carry;

    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            if (i_ctrl.point) begin
                n_lo[a] = i_lo_cell[a];
                n_hi[a] = i_lo_cell[a];
            end else if (i_hi_cell[a] < i_lo_cell[a]) begin
                n_lo[a] = i_hi_cell[a];
                n_hi[a] = i_lo_cell[a];
            end else begin
                n_lo[a] = i_lo_cell[a];
                n_hi[a] = i_hi_cell[a];
            end
        end
    end

    always_comb begin
        n_step  = r_idx;
        w_carry = 1'b1;
        for (int a = AXES - 1; a >= 0; a--) begin
            if (w_carry) begin
                if (r_idx[a] < r_hi[a]) begin
                    n_step[a] = CELL_W'(r_idx[a] + CELL_W'(1));
                    w_carry   = 1'b0;
                end else begin
                    n_step[a] = r_lo[a];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_lo  <= n_lo;
            r_hi  <= n_hi;
            r_idx <= n_lo;
        end else if (i_ctrl.step) begin
            r_idx <= n_step;
        end
    end

    assign o_item.tile_id = flat_tile(r_idx, i_k);
    assign o_item.last    = (r_idx == r_hi);

endmodule

>>> src/grid_cell_mapper_and_box_enumerator_core.sv
// ============================================================================
// grid_cell_mapper_and_box_enumerator_core
// Maps a point to its grid tile id, or lists every tile a query box covers.
// The first result reaches o_result through the lane offset, lane multiply, range
// merge and output registers, then one tile id follows per cycle.
// busy stays high until the walker has stepped past the last tile id of an item;
// no new item is taken before that.
// Reset: synchronous, active low; clears config to defaults and the sequencer.
// The receiver cannot stall: each result is shown for exactly one cycle.
// ============================================================================
module grid_cell_mapper_and_box_enumerator_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    input  gcm_pkg::t_in_item                   i_item,
    output logic                                busy,
    output logic                                o_valid,
    output gcm_pkg::t_out_item                  o_result,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [gcm_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [gcm_pkg::DATA_W-1:0]          i_cfg_data
);
    import gcm_pkg::*;

    t_state                    r_state;
    t_state                    n_state;
    t_cmd                      r_cmd;
    logic signed [DATA_W-1:0]  r_origin [AXES];
    logic        [DATA_W-1:0]  r_scale  [AXES];
    logic        [K_W-1:0]     r_cells;
    logic                      r_out_valid;
    t_out_item                 r_out;

    logic                      w_accept;
    logic                      w_cfg_wr;
    logic        [K_W-1:0]     w_k;
    logic signed [DATA_W-1:0]  w_lo_val [AXES];
    logic signed [DATA_W-1:0]  w_hi_val [AXES];
    t_cells                    w_lo_cell;
    t_cells                    w_hi_cell;
    t_merge_ctrl               w_ctrl;
    t_out_item                 w_item;

    assign busy        = (r_state != ST_IDLE);
    assign w_accept    = start && !busy;
    assign o_cfg_ready = !busy && !start;
    assign w_cfg_wr    = i_cfg_valid && o_cfg_ready;
    assign w_k         = grid_k(r_cells);

    assign w_lo_val[0] = i_item.pos_0;
    assign w_lo_val[1] = i_item.pos_1;
    assign w_lo_val[2] = i_item.pos_2;
    assign w_hi_val[0] = i_item.upper_0;
    assign w_hi_val[1] = i_item.upper_1;
    assign w_hi_val[2] = i_item.upper_2;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < AXES; a++) begin
                r_origin[a] <= '0;
                r_scale[a]  <= '0;
            end
            r_cells <= K_W'(1);
        end else if (w_cfg_wr) begin
            case (i_cfg_index)
                CFG_ORIGIN0: r_origin[0] <= i_cfg_data;
                CFG_ORIGIN1: r_origin[1] <= i_cfg_data;
                CFG_ORIGIN2: r_origin[2] <= i_cfg_data;
                CFG_SCALE0:  r_scale[0]  <= i_cfg_data;
                CFG_SCALE1:  r_scale[1]  <= i_cfg_data;
                CFG_SCALE2:  r_scale[2]  <= i_cfg_data;
                CFG_CELLS:   r_cells     <= i_cfg_data[K_W-1:0];
                default: ;
            endcase
        end
    end

    genvar g;
    generate
        for (g = 0; g < AXES; g++) begin : g_lane
            gcm_axis_lane u_lo (
                .i_clk    (i_clk),
                .i_load   (w_accept),
                .i_mul    (r_state == ST_DIFF),
                .i_value  (w_lo_val[g]),
                .i_origin (r_origin[g]),
                .i_scale  (r_scale[g]),
                .i_k      (w_k),
                .o_cell   (w_lo_cell[g])
            );
            gcm_axis_lane u_hi (
                .i_clk    (i_clk),
                .i_load   (w_accept),
                .i_mul    (r_state == ST_DIFF),
                .i_value  (w_hi_val[g]),
                .i_origin (r_origin[g]),
                .i_scale  (r_scale[g]),
                .i_k      (w_k),
                .o_cell   (w_hi_cell[g])
            );
        end
    endgenerate

    gcm_box_merge u_merge (
        .i_clk     (i_clk),
        .i_ctrl    (w_ctrl),
        .i_k       (w_k),
        .i_lo_cell (w_lo_cell),
        .i_hi_cell (w_hi_cell),
        .o_item    (w_item)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= (r_state == ST_EMIT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= i_item.cmd;
        end
        r_out <= w_item;
    end

    always_comb begin
        n_state      = r_state;
        w_ctrl.load  = 1'b0;
        w_ctrl.step  = 1'b0;
        w_ctrl.point = (r_cmd == CMD_POINT);
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_DIFF;
                end
            end
            ST_DIFF: begin
                n_state = ST_MUL;
            end
            ST_MUL: begin
                w_ctrl.load = 1'b1;
                n_state     = ST_EMIT;
            end
            ST_EMIT: begin
                w_ctrl.step = 1'b1;
                if (w_item.last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

>>> src/gcm_checker.sv
// ============================================================================
// gcm_checker
// Port-level timing checks for the grid cell mapper core, bound to the top.
// ============================================================================
module gcm_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    input  logic                                busy,
    input  logic                                o_valid,
    input  gcm_pkg::t_out_item                  o_result,
    input  logic                                i_cfg_valid,
    input  logic                                o_cfg_ready
);
    import gcm_pkg::*;

    // o_valid stays low after acceptance until the first result of the transaction
    a_first_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##1 !o_valid ##1 !o_valid ##1 !o_valid ##1 o_valid)
        else $error("first result not three cycles after acceptance");

    // results of one transaction come back to back
    a_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_result.last) |=> o_valid)
        else $error("gap inside a result run");

    // a final result is followed by an idle output cycle
    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.last) |=> !o_valid)
        else $error("result after final result");

    // tile ids are never zero
    a_tile_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result.tile_id != '0))
        else $error("zero tile id");

    // config lands only while no transaction is in flight or starting
    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_cfg_ready) |-> (!busy && !start))
        else $error("config write during a transaction");

endmodule

bind grid_cell_mapper_and_box_enumerator_core gcm_checker u_gcm_checker (.*);
